// File: hdl/qte_pkg.sv
`timescale 1ns / 1ps

package qte_pkg;

  localparam int QUAT_BITS_DEF    = 16;
  localparam int CORDIC_STEPS_DEF = 16;

  // term width: Q30 values reach 4.0 in magnitude (2*(xy+wz) with |x|,|y| up to 1)
  localparam int TERM_W = 34;
  // CORDIC datapath: term grows by up to 1.65 and after the x-negation pre-rotate
  localparam int CW = TERM_W + 3;
  // angle accumulator, 1/65536 centidegree
  localparam int ZW = 36;

  localparam longint ANG_180 = 64'sd1179648000;
  localparam longint Q30_ONE = 64'sd1073741824;

  localparam logic [15:0] DECL_RESET = 16'sd1380;

  function automatic logic signed [ZW-1:0] atan_entry(input int i);
    logic signed [ZW-1:0] r;
    case (i)
      0: r = 36'sd294912000;  1: r = 36'sd174096719; 2: r = 36'sd91987925;
      3: r = 36'sd46694507;   4: r = 36'sd23437865;  5: r = 36'sd11730358;
      6: r = 36'sd5866610;    7: r = 36'sd2933484;   8: r = 36'sd1466764;
      9: r = 36'sd733385;     10: r = 36'sd366693;   11: r = 36'sd183347;
      12: r = 36'sd91673;     13: r = 36'sd45837;    14: r = 36'sd22918;
      15: r = 36'sd11459;     16: r = 36'sd5730;     17: r = 36'sd2865;
      18: r = 36'sd1432;      19: r = 36'sd716;      20: r = 36'sd358;
      21: r = 36'sd179;       22: r = 36'sd90;       23: r = 36'sd45;
      24: r = 36'sd22;        25: r = 36'sd11;       26: r = 36'sd6;
      27: r = 36'sd3;         28: r = 36'sd1;        29: r = 36'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

  // CORDIC lane carried through the pipeline
  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 zero;
  } lane_t;

endpackage

// File: hdl/quaternion_to_euler_heading.sv
`timescale 1ns / 1ps
// Quaternion to Euler angles (yaw with declination, pitch, roll).
// Input channel s_axis: one transaction carries a quaternion w,x,y,z in
// signed Q1.(QUAT_BITS-1). Output channel m_axis: one transaction per input
// carrying yaw (0..35999), pitch, roll in centidegrees and the arcsine
// clamp flag. Config: decl_we/decl_wdata write the declination register;
// the user writes it only while no transaction is in flight; the block itself leaves this unchecked.
// Throughput: one transaction per cycle while m_axis_tready does not stall the
// output. CORDIC steps are capped at 32. The pipeline has, from input to output:
// three front stages (products, matrix terms, clamp and radicand), 31
// square-root stages of one result bit each, one pre-rotation stage, one
// stage per CORDIC iteration and two output stages; pitch, roll and yaw
// CORDICs run in parallel lanes.
// The whole pipeline advances as one: when m_axis_tready is low with a
// result waiting, every stage holds and s_axis_tready drops; nothing is
// lost or repeated.
// Reset (rst, synchronous) clears all valid bits and sets declination to
// 13.80 degrees.
module quaternion_to_euler_heading #(
  parameter int QUAT_BITS    = qte_pkg::QUAT_BITS_DEF,
  parameter int CORDIC_STEPS = qte_pkg::CORDIC_STEPS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // quat_w, quat_x, quat_y, quat_z from bit 0 up
  input  logic [4*QUAT_BITS-1:0] s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // yaw_centideg[15:0], pitch_centideg[30:16], roll_centideg[46:31], pad
  output logic [47:0]            m_axis_tdata,
  // clamp_flag
  output logic                   m_axis_tuser,
  input  logic                   decl_we,
  input  logic [15:0]            decl_wdata
);

  localparam int TW  = qte_pkg::TERM_W;
  localparam int CW  = qte_pkg::CW;
  localparam int ZW  = qte_pkg::ZW;
  localparam int NS  = (CORDIC_STEPS < 32) ? CORDIC_STEPS : 32;
  localparam int PW  = 2 * QUAT_BITS;
  localparam int FB  = 2 * (QUAT_BITS - 1);
  localparam int SQB = 31;             // result bits of sqrt(2^60 - s^2)
  localparam int RW  = 64;
  // stages: 0 prod, 1 sums, 2 clamp/square, sqrt SQB, pre 1, cordic NS, post 2
  localparam int NSTG = 3 + SQB + 1 + NS + 2;

  logic        adv;
  logic [NSTG-1:0] vld;
  logic signed [15:0] decl;

  assign adv = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      decl <= qte_pkg::DECL_RESET;
      vld  <= '0;
    end else begin
      if (decl_we) decl <= decl_wdata;
      if (adv) vld <= {vld[NSTG-2:0], s_axis_tvalid};
    end
  end
  assign m_axis_tvalid = vld[NSTG-1];

  function automatic logic signed [TW-1:0] q30(input logic signed [PW-1:0] p);
    logic signed [TW+PW-1:0] e;
    e = {{TW{p[PW-1]}}, p};
    if (FB > 30) return TW'(e >>> (FB - 30));
    return TW'(e <<< (30 - FB));
  endfunction

  // stage 0: ten products
  logic signed [QUAT_BITS-1:0] qw, qx, qy, qz;
  assign qw = s_axis_tdata[0*QUAT_BITS +: QUAT_BITS];
  assign qx = s_axis_tdata[1*QUAT_BITS +: QUAT_BITS];
  assign qy = s_axis_tdata[2*QUAT_BITS +: QUAT_BITS];
  assign qz = s_axis_tdata[3*QUAT_BITS +: QUAT_BITS];
  logic signed [TW-1:0] pww, pxx, pyy, pzz, pxy, pwz, pwx, pyz, pxz, pwy;
  always_ff @(posedge clk) begin
    if (adv) begin
      pww <= q30(qw * qw); pxx <= q30(qx * qx); pyy <= q30(qy * qy);
      pzz <= q30(qz * qz); pxy <= q30(qx * qy); pwz <= q30(qw * qz);
      pwx <= q30(qw * qx); pyz <= q30(qy * qz); pxz <= q30(qx * qz);
      pwy <= q30(qw * qy);
    end
  end

  // stage 1: matrix terms
  logic signed [TW-1:0] a12, a22, a31, a32, a33;
  always_ff @(posedge clk) begin
    if (adv) begin
      a12 <= (pxy + pwz) <<< 1;
      a22 <= pww + pxx - pyy - pzz;
      a31 <= (pwx + pyz) <<< 1;
      a32 <= (pxz - pwy) <<< 1;
      a33 <= pww - pxx - pyy + pzz;
    end
  end

  // stage 2: clamp and radicand
  logic signed [TW-1:0] s_cl;
  logic                 clp;
  always_comb begin
    clp  = 1'b0;
    s_cl = a32;
    if (a32 > TW'(qte_pkg::Q30_ONE)) begin
      s_cl = TW'(qte_pkg::Q30_ONE); clp = 1'b1;
    end else if (a32 < -TW'(qte_pkg::Q30_ONE)) begin
      s_cl = -TW'(qte_pkg::Q30_ONE); clp = 1'b1;
    end
  end
  logic signed [31:0] s2;
  assign s2 = 32'(s_cl);

  typedef struct packed {
    logic signed [CW-1:0] s;
    logic signed [CW-1:0] x31;
    logic signed [CW-1:0] y33;
    logic signed [CW-1:0] x12;
    logic signed [CW-1:0] y22;
    logic                 clp;
  } side_t;

  typedef struct packed {
    logic [RW-1:0] v;
    logic [RW-1:0] r;
  } sq_t;

  side_t side [SQB+1];
  sq_t   sq   [SQB+1];
  logic [RW-1:0] s2sq;
  // |s| is at most 2^30, so the square needs the full 64-bit product
  assign s2sq = RW'($unsigned(64'(s2) * 64'(s2)));

  always_ff @(posedge clk) begin
    if (adv) begin
      side[0] <= '{s: CW'(s_cl), x31: CW'(a31), y33: CW'(a33), x12: CW'(a12),
                   y22: CW'(a22), clp: clp};
      sq[0]   <= '{v: (RW'(1) << 60) - s2sq, r: '0};
    end
  end

  // square root, one result bit per stage (bit weights 4^30 down to 4^0)
  for (genvar k = 0; k < SQB; k++) begin : g_sqrt
    localparam logic [RW-1:0] BIT = RW'(1) << (2 * (SQB - 1 - k));
    always_ff @(posedge clk) begin
      if (adv) begin
        side[k+1] <= side[k];
        if (sq[k].v >= sq[k].r + BIT) begin
          sq[k+1].v <= sq[k].v - (sq[k].r + BIT);
          sq[k+1].r <= (sq[k].r >> 1) + BIT;
        end else begin
          sq[k+1].v <= sq[k].v;
          sq[k+1].r <= sq[k].r >> 1;
        end
      end
    end
  end

  // pre-rotation for three lanes
  function automatic qte_pkg::lane_t pre(input logic signed [CW-1:0] y,
                                         input logic signed [CW-1:0] x);
    qte_pkg::lane_t l;
    l.zero = (x == 0) && (y == 0);
    l.x = x; l.y = y; l.z = '0;
    if (x < 0) begin
      l.z = (y >= 0) ? ZW'(qte_pkg::ANG_180) : -ZW'(qte_pkg::ANG_180);
      l.x = -x; l.y = -y;
    end
    return l;
  endfunction

  function automatic qte_pkg::lane_t rot(input qte_pkg::lane_t l, input int i);
    qte_pkg::lane_t o;
    o = l;
    if (l.y > 0) begin
      o.x = l.x + (l.y >>> i); o.y = l.y - (l.x >>> i);
      o.z = l.z + qte_pkg::atan_entry(i);
    end else begin
      o.x = l.x - (l.y >>> i); o.y = l.y + (l.x >>> i);
      o.z = l.z - qte_pkg::atan_entry(i);
    end
    return o;
  endfunction

  qte_pkg::lane_t lp [NS+1], lr [NS+1], ly [NS+1];
  logic clf [NS+1];
  always_ff @(posedge clk) begin
    if (adv) begin
      lp[0] <= pre(side[SQB].s, CW'(sq[SQB].r));
      lr[0] <= pre(side[SQB].x31, side[SQB].y33);
      ly[0] <= pre(side[SQB].x12, side[SQB].y22);
      clf[0] <= side[SQB].clp;
    end
  end

  for (genvar i = 0; i < NS; i++) begin : g_cordic
    always_ff @(posedge clk) begin
      if (adv) begin
        lp[i+1] <= rot(lp[i], i);
        lr[i+1] <= rot(lr[i], i);
        ly[i+1] <= rot(ly[i], i);
        clf[i+1] <= clf[i];
      end
    end
  end

  function automatic logic signed [19:0] rnd(input qte_pkg::lane_t l);
    logic [ZW-1:0] m;
    logic signed [ZW-1:0] t;
    if (l.zero) return '0;
    if (l.z >= 0) begin
      t = (l.z + ZW'(32768)) >>> 16;
      return 20'(t);
    end
    m = ZW'(-l.z) + ZW'(32768);
    return -20'(m >> 16);
  endfunction

  function automatic logic signed [19:0] sat(input logic signed [19:0] v,
                                             input logic signed [19:0] lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // post 1: round, saturate, add declination
  logic signed [19:0] pit1, rol1, yaw1;
  logic               clf1;
  always_ff @(posedge clk) begin
    if (adv) begin
      pit1 <= sat(-rnd(lp[NS]), 20'sd9000);
      rol1 <= sat(rnd(lr[NS]), 20'sd18000);
      yaw1 <= rnd(ly[NS]) + 20'(decl);
      clf1 <= clf[NS];
    end
  end

  // post 2: wrap yaw; sum lies in (-54000, 54000)
  logic signed [19:0] yw;
  always_comb begin
    yw = yaw1;
    if (yw >= 20'sd36000) yw = yw - 20'sd36000;
    else if (yw < 0) yw = yw + 20'sd36000;
    if (yw < 0) yw = yw + 20'sd36000;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      m_axis_tdata <= {1'b0, rol1[15:0], pit1[14:0], yw[15:0]};
      m_axis_tuser <= clf1;
    end
  end

endmodule

// File: hdl/qte_checker.sv
`timescale 1ns / 1ps

module qte_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata
);

  a_ready: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
    else $error("input taken while output stalled");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata) && m_axis_tvalid)
    else $error("stalled result changed");

  a_yaw: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[15:0] < 16'd36000)
    else $error("yaw out of range");

  a_rst: assert property (@(posedge clk) $past(rst) |-> !m_axis_tvalid)
    else $error("valid after reset");

endmodule

bind quaternion_to_euler_heading qte_checker u_qte_checker (
  .clk(clk), .rst(rst), .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata)
);
